### src/lrch_pkg.sv
// Shared types, constants and codes for the LED ring clock hands block.
package lrch_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 48;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);

  // Register reset values and tick timer reload values per mode
  localparam logic [9:0]  MINUTE_DIV_RESET = 10'd60;
  localparam logic [11:0] HOUR_DIV_RESET   = 12'd720;
  localparam logic [23:0] RUN_RELOAD_RESET = 24'd234375;
  localparam logic [23:0] PERIOD_SET_HOUR  = 24'd250;
  localparam logic [23:0] PERIOD_SET_MIN   = 24'd1000;
  localparam logic [23:0] PERIOD_SET_SEC   = 24'd2500;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam int          CFG_AW         = 4;
  localparam logic [1:0]  REG_MINUTE_DIV = 2'd0;
  localparam logic [1:0]  REG_HOUR_DIV   = 2'd1;
  localparam logic [1:0]  REG_RUN_RELOAD = 2'd2;

  // Hand selection
  localparam logic [1:0] HAND_SEC  = 2'd0;
  localparam logic [1:0] HAND_MIN  = 2'd1;
  localparam logic [1:0] HAND_HOUR = 2'd2;

  typedef enum logic [2:0] {
    MODE_RUN      = 3'd0,
    MODE_SET_HOUR = 3'd1,
    MODE_SET_MIN  = 3'd2,
    MODE_SET_SEC  = 3'd3,
    MODE_PAUSE    = 3'd4
  } clock_mode_t;

  typedef struct packed {
    logic mode;
    logic switch_level;
  } event_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [5:0]  byte_pos;
    logic [7:0]  pixel_byte;
    logic        last;
    logic [2:0]  clock_mode;
    logic [23:0] tick_reload;
    logic [1:0]  led_toggles;
  } result_item_t;

  typedef struct packed {
    logic [9:0]  minute_divider;
    logic [11:0] hour_divider;
    logic [23:0] run_reload;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MODE,
    ST_STATUS,
    ST_COUNT,
    ST_RD_LO,
    ST_WR_LO,
    ST_RD_HI,
    ST_WR_HI,
    ST_ADV_RD,
    ST_ADV_UPD,
    ST_PRIME,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_MODE,
    DP_STATUS,
    DP_COUNT,
    DP_RD_LO,
    DP_WR_LO,
    DP_RD_HI,
    DP_WR_HI,
    DP_ADV_RD,
    DP_ADV_UPD,
    DP_PRIME,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] hand;
  } dp_cmd_t;

  typedef struct packed {
    logic is_switch;
    logic paused;
    logic step_min;
    logic step_hour;
    logic slot_free;
    logic emit_last;
  } dp_stat_t;

endpackage

### src/lrch_regs.sv
// Configuration register file behind the APB-style port.
module lrch_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrch_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lrch_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register; unused addresses drop the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.minute_divider <= lrch_pkg::MINUTE_DIV_RESET;
      cfg.hour_divider   <= lrch_pkg::HOUR_DIV_RESET;
      cfg.run_reload     <= lrch_pkg::RUN_RELOAD_RESET;
    end else if (wr_en) begin
      if (reg_idx == lrch_pkg::REG_MINUTE_DIV) begin
        cfg.minute_divider <= pwdata[9:0];
      end
      if (reg_idx == lrch_pkg::REG_HOUR_DIV) begin
        cfg.hour_divider <= pwdata[11:0];
      end
      if (reg_idx == lrch_pkg::REG_RUN_RELOAD) begin
        cfg.run_reload <= pwdata[23:0];
      end
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      lrch_pkg::REG_MINUTE_DIV: prdata = {22'd0, cfg.minute_divider};
      lrch_pkg::REG_HOUR_DIV:   prdata = {20'd0, cfg.hour_divider};
      lrch_pkg::REG_RUN_RELOAD: prdata = {8'd0, cfg.run_reload};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### src/lrch_ctrl.sv
// Controller state machine sequencing tick, switch and frame emission work.
module lrch_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               event_valid,
  output logic               event_stall,
  input  lrch_pkg::dp_stat_t stat,
  output lrch_pkg::dp_cmd_t  cmd
);

  lrch_pkg::ctrl_state_t state, state_next;
  logic [1:0]            hand, hand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrch_pkg::ST_IDLE;
      hand  <= lrch_pkg::HAND_SEC;
    end else begin
      state <= state_next;
      hand  <= hand_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    hand_next  = hand;
    unique case (state)
      lrch_pkg::ST_IDLE: begin
        if (event_valid) begin
          state_next = lrch_pkg::ST_DECIDE;
        end
      end
      lrch_pkg::ST_DECIDE: begin
        priority if (stat.is_switch) begin
          state_next = lrch_pkg::ST_MODE;
        end else if (stat.paused) begin
          state_next = lrch_pkg::ST_IDLE;
        end else begin
          state_next = lrch_pkg::ST_COUNT;
        end
      end
      lrch_pkg::ST_MODE:   state_next = lrch_pkg::ST_STATUS;
      lrch_pkg::ST_STATUS: begin
        if (stat.slot_free) begin
          state_next = lrch_pkg::ST_IDLE;
        end
      end
      lrch_pkg::ST_COUNT: begin
        state_next = lrch_pkg::ST_RD_LO;
        hand_next  = lrch_pkg::HAND_SEC;
      end
      lrch_pkg::ST_RD_LO: state_next = lrch_pkg::ST_WR_LO;
      lrch_pkg::ST_WR_LO: state_next = lrch_pkg::ST_RD_HI;
      lrch_pkg::ST_RD_HI: state_next = lrch_pkg::ST_WR_HI;
      lrch_pkg::ST_WR_HI: begin
        // Step the next flagged hand, or move on to the position updates
        priority if (hand == lrch_pkg::HAND_SEC && stat.step_min) begin
          state_next = lrch_pkg::ST_RD_LO;
          hand_next  = lrch_pkg::HAND_MIN;
        end else if (hand != lrch_pkg::HAND_HOUR && stat.step_hour) begin
          state_next = lrch_pkg::ST_RD_LO;
          hand_next  = lrch_pkg::HAND_HOUR;
        end else begin
          state_next = lrch_pkg::ST_ADV_RD;
          hand_next  = lrch_pkg::HAND_SEC;
        end
      end
      lrch_pkg::ST_ADV_RD: state_next = lrch_pkg::ST_ADV_UPD;
      lrch_pkg::ST_ADV_UPD: begin
        if (hand == lrch_pkg::HAND_HOUR) begin
          state_next = lrch_pkg::ST_PRIME;
        end else begin
          state_next = lrch_pkg::ST_ADV_RD;
          hand_next  = hand + 2'd1;
        end
      end
      lrch_pkg::ST_PRIME: state_next = lrch_pkg::ST_EMIT;
      lrch_pkg::ST_EMIT: begin
        if (stat.slot_free && stat.emit_last) begin
          state_next = lrch_pkg::ST_IDLE;
        end
      end
      default: state_next = lrch_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    event_stall = (state != lrch_pkg::ST_IDLE);
    cmd.hand    = hand;
    unique case (state)
      lrch_pkg::ST_IDLE:    cmd.op = event_valid ? lrch_pkg::DP_LATCH : lrch_pkg::DP_NONE;
      lrch_pkg::ST_MODE:    cmd.op = lrch_pkg::DP_MODE;
      lrch_pkg::ST_STATUS:  cmd.op = lrch_pkg::DP_STATUS;
      lrch_pkg::ST_COUNT:   cmd.op = lrch_pkg::DP_COUNT;
      lrch_pkg::ST_RD_LO:   cmd.op = lrch_pkg::DP_RD_LO;
      lrch_pkg::ST_WR_LO:   cmd.op = lrch_pkg::DP_WR_LO;
      lrch_pkg::ST_RD_HI:   cmd.op = lrch_pkg::DP_RD_HI;
      lrch_pkg::ST_WR_HI:   cmd.op = lrch_pkg::DP_WR_HI;
      lrch_pkg::ST_ADV_RD:  cmd.op = lrch_pkg::DP_ADV_RD;
      lrch_pkg::ST_ADV_UPD: cmd.op = lrch_pkg::DP_ADV_UPD;
      lrch_pkg::ST_PRIME:   cmd.op = lrch_pkg::DP_PRIME;
      lrch_pkg::ST_EMIT:    cmd.op = lrch_pkg::DP_EMIT;
      default:              cmd.op = lrch_pkg::DP_NONE;
    endcase
  end

endmodule

### src/lrch_datapath.sv
// Datapath: frame memory, hand positions, tick counters, mode state and result register.
module lrch_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lrch_pkg::cfg_t         cfg,
  input  lrch_pkg::event_item_t  event_item,
  input  lrch_pkg::dp_cmd_t      cmd,
  output lrch_pkg::dp_stat_t     stat,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lrch_pkg::result_item_t result_item
);

  localparam int AW = lrch_pkg::FRAME_AW;
  localparam logic [AW:0]   FB_W    = (AW+1)'(lrch_pkg::FRAME_BYTES);
  localparam logic [AW-1:0] LAST_IX = AW'(lrch_pkg::FRAME_BYTES - 1);

  // Latched transaction and clock state
  logic                  ev_q;
  logic                  sw_q;
  lrch_pkg::clock_mode_t clock_state;
  logic [23:0]           tick_period;
  logic [1:0]            indicator;
  logic [9:0]            min_cnt;
  logic [11:0]           hr_cnt;
  logic                  step_min;
  logic                  step_hour;
  logic [AW-1:0]         pos_sec;
  logic [AW-1:0]         pos_min;
  logic [AW-1:0]         pos_hour;
  logic [AW-1:0]         emit_idx;

  // Frame memory with per-entry written flags
  logic [7:0]              frame_mem [lrch_pkg::FRAME_BYTES];
  logic [lrch_pkg::FRAME_BYTES-1:0] frame_written;
  logic [7:0]              rd_mem_q;
  logic                    rd_written_q;
  logic [AW-1:0]           rd_addr_q;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [7:0]              wdata;
  logic [7:0]              rdata;

  logic [AW-1:0] pos_cur;
  logic [AW-1:0] pos_ahead;
  logic [9:0]    min_inc;
  logic [11:0]   hr_inc;
  logic          slot_free;
  logic          emit_last;
  logic          load_status;
  logic          load_emit;

  function automatic logic [AW-1:0] ahead(input logic [AW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(3);
    return (s >= FB_W) ? AW'(s - FB_W) : AW'(s);
  endfunction

  function automatic logic [7:0] frame_init(input logic [AW-1:0] a);
    return (a < AW'(3)) ? 8'hFF : 8'h00;
  endfunction

  // Select the hand under work
  always_comb begin
    unique case (cmd.hand)
      lrch_pkg::HAND_MIN:  pos_cur = pos_min;
      lrch_pkg::HAND_HOUR: pos_cur = pos_hour;
      default:             pos_cur = pos_sec;
    endcase
  end

  assign pos_ahead = ahead(pos_cur);
  assign min_inc   = min_cnt + 10'd1;
  assign hr_inc    = hr_cnt + 12'd1;
  assign slot_free = !result_valid || !result_stall;
  assign emit_last = (emit_idx == LAST_IX);
  assign load_status = (cmd.op == lrch_pkg::DP_STATUS) && slot_free;
  assign load_emit   = (cmd.op == lrch_pkg::DP_EMIT) && slot_free;

  // Memory port control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos_cur;
    wdata = rdata - 8'd1;
    unique case (cmd.op)
      lrch_pkg::DP_RD_LO:  raddr = pos_cur;
      lrch_pkg::DP_WR_LO:  we = 1'b1;
      lrch_pkg::DP_RD_HI:  raddr = pos_ahead;
      lrch_pkg::DP_WR_HI: begin
        we    = 1'b1;
        waddr = pos_ahead;
        wdata = rdata + 8'd1;
      end
      lrch_pkg::DP_ADV_RD: raddr = pos_ahead;
      lrch_pkg::DP_EMIT: begin
        // Hold the current byte while stalled, fetch the next one on a load
        if (load_emit) begin
          raddr = emit_last ? '0 : emit_idx + AW'(1);
        end else begin
          raddr = emit_idx;
        end
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem[waddr] <= wdata;
    end
    rd_mem_q  <= frame_mem[raddr];
    rd_addr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_written <= '0;
      rd_written_q  <= 1'b0;
    end else begin
      if (we) begin
        frame_written[waddr] <= 1'b1;
      end
      rd_written_q <= frame_written[raddr];
    end
  end

  assign rdata = rd_written_q ? rd_mem_q : frame_init(rd_addr_q);

  // Clock state, counters and hand positions
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_q        <= 1'b0;
      sw_q        <= 1'b0;
      clock_state <= lrch_pkg::MODE_RUN;
      tick_period <= lrch_pkg::RUN_RELOAD_RESET;
      indicator   <= 2'b00;
      min_cnt     <= '0;
      hr_cnt      <= '0;
      step_min    <= 1'b0;
      step_hour   <= 1'b0;
      pos_sec     <= AW'(0);
      pos_min     <= AW'(1);
      pos_hour    <= AW'(2);
      emit_idx    <= '0;
    end else begin
      unique case (cmd.op)
        lrch_pkg::DP_LATCH: begin
          ev_q <= event_item.mode;
          sw_q <= event_item.switch_level;
        end
        lrch_pkg::DP_MODE: begin
          // Step the mode cycle on a high switch level
          if (sw_q) begin
            unique case (clock_state)
              lrch_pkg::MODE_RUN: begin
                indicator[0] <= ~indicator[0];
                clock_state  <= lrch_pkg::MODE_SET_HOUR;
                tick_period  <= lrch_pkg::PERIOD_SET_HOUR;
              end
              lrch_pkg::MODE_SET_HOUR: begin
                clock_state <= lrch_pkg::MODE_SET_MIN;
                tick_period <= lrch_pkg::PERIOD_SET_MIN;
              end
              lrch_pkg::MODE_SET_MIN: begin
                clock_state <= lrch_pkg::MODE_SET_SEC;
                tick_period <= lrch_pkg::PERIOD_SET_SEC;
              end
              lrch_pkg::MODE_SET_SEC: begin
                indicator[1] <= ~indicator[1];
                clock_state  <= lrch_pkg::MODE_PAUSE;
              end
              lrch_pkg::MODE_PAUSE: begin
                indicator[1] <= ~indicator[1];
                clock_state  <= lrch_pkg::MODE_RUN;
                tick_period  <= cfg.run_reload;
              end
              default: clock_state <= clock_state;
            endcase
          end
        end
        lrch_pkg::DP_COUNT: begin
          // Advance both tick counters and flag the hands that step
          step_min  <= (min_inc >= cfg.minute_divider);
          step_hour <= (hr_inc >= cfg.hour_divider);
          min_cnt   <= (min_inc >= cfg.minute_divider) ? 10'd0 : min_inc;
          hr_cnt    <= (hr_inc >= cfg.hour_divider) ? 12'd0 : hr_inc;
        end
        lrch_pkg::DP_ADV_UPD: begin
          // Move the hand on once the byte ahead is full
          if (rdata == 8'hFF) begin
            unique case (cmd.hand)
              lrch_pkg::HAND_MIN:  pos_min  <= pos_ahead;
              lrch_pkg::HAND_HOUR: pos_hour <= pos_ahead;
              default:             pos_sec  <= pos_ahead;
            endcase
          end
        end
        lrch_pkg::DP_PRIME: emit_idx <= '0;
        lrch_pkg::DP_EMIT: begin
          if (load_emit) begin
            emit_idx <= emit_last ? '0 : emit_idx + AW'(1);
          end
        end
        default: emit_idx <= emit_idx;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_status || load_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status || load_emit) begin
      result_item.frame_valid <= load_emit;
      result_item.byte_pos    <= load_emit ? 6'(emit_idx) : 6'd0;
      result_item.pixel_byte  <= load_emit ? rdata : 8'd0;
      result_item.last        <= load_status || emit_last;
      result_item.clock_mode  <= clock_state;
      result_item.tick_reload <= tick_period;
      result_item.led_toggles <= indicator;
    end
  end

  // Status to the controller
  always_comb begin
    stat.is_switch = ev_q;
    stat.paused    = (clock_state == lrch_pkg::MODE_PAUSE);
    stat.step_min  = step_min;
    stat.step_hour = step_hour;
    stat.slot_free = slot_free;
    stat.emit_last = emit_last;
  end

endmodule

### src/led_ring_clock_hands.sv
// Top level of the LED ring clock hands block.
//
// Event channel (event_valid/event_stall/event_item): each transaction is a
// timer tick (mode 0) or a switch event (mode 1, with the sampled switch level).
// Result channel (result_valid/result_stall/result_item): a tick emits the
// 48 GRB frame bytes in order, the final one marked last; a switch event
// emits one status result carrying the new mode. Every result carries the
// current mode, tick reload value and indicator bits.
// A switch event passes the decide and mode states before its status result is loaded.
// A tick is decided and counted, then each stepped hand (1 to 3 hands) has two frame
// bytes read and rewritten, the byte ahead of each hand is read for the position
// updates, the first read is primed, and the frame streams out one byte per cycle
// while the receiver does not stall, 48 in all. A paused tick is dropped in the decide
// state. A new transaction is taken only once the previous one has finished. The
// receiver may stall at any time; the result register holds its transaction and
// emission waits. Reset (rst, synchronous) restores the starting frame (first pixel
// lit by all three hands) and run mode, and empties the result register. Configuration
// must be written through the APB port while idle; the block does not enforce it.
module led_ring_clock_hands (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        event_valid,
  output logic                        event_stall,
  input  lrch_pkg::event_item_t       event_item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output lrch_pkg::result_item_t      result_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrch_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lrch_pkg::cfg_t     cfg;
  lrch_pkg::dp_cmd_t  cmd;
  lrch_pkg::dp_stat_t stat;

  lrch_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrch_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  lrch_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .event_item   (event_item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

### src/lrch_checker.sv
// Port-level checks for the LED ring clock hands block, bound to the top level.
module lrch_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   event_valid,
  input logic                   event_stall,
  input lrch_pkg::event_item_t  event_item,
  input logic                   result_valid,
  input logic                   result_stall,
  input lrch_pkg::result_item_t result_item
);

  // Hold a stalled event transaction
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(event_item))
    else $error("stalled event transaction changed");

  // Hold a stalled result transaction
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result transaction changed");

  // Mark the last frame byte and only that one
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.frame_valid |->
      result_item.last == (result_item.byte_pos == 6'(lrch_pkg::FRAME_BYTES - 1)))
    else $error("last flag does not match final frame byte");

  // Status results are single, empty transactions
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.frame_valid |->
      result_item.last && result_item.byte_pos == 6'd0 && result_item.pixel_byte == 8'd0)
    else $error("malformed status result");

  // Empty the result register on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

endmodule

bind led_ring_clock_hands lrch_checker u_lrch_checker (
  .clk          (clk),
  .rst          (rst),
  .event_valid  (event_valid),
  .event_stall  (event_stall),
  .event_item   (event_item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
